// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/krt_pkg.sv =====
// Package with the constants, codes and interface types of the keyed record table.
package krt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W     = 32;
    localparam int REC_W       = 2 * FIELD_W;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LIST   = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_UPDATE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_INSERT,
        OP_FULL,
        OP_EMPTY,
        OP_NOTFOUND,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_SCAN_HIT,
        OP_SORT_INIT,
        OP_PASS_LOAD,
        OP_PASS_RUN,
        OP_PASS_END,
        OP_LIST_INIT,
        OP_LIST_NEXT
    } dp_op_t;

    typedef struct packed {
        req_t req;
        logic empty;
        logic full;
        logic few;
        logic match;
        logic at_last;
        logic run_end;
        logic sort_end;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_CHK,
        S_PASS_LOAD,
        S_PASS_RUN,
        S_PASS_END,
        S_LIST_OUT
    } ctl_state_t;

endpackage

// ===== rtl/krt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/krt_dpath.sv =====
// Datapath of the record table: record RAM, index registers, sort carry and result registers.
module krt_dpath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               req_type,
    input  logic signed [31:0]       key_id,
    input  logic signed [31:0]       salary_value,
    input  krt_pkg::dp_op_t          op,
    output krt_pkg::dp_stat_t        stat,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [31:0]       rec_id,
    output logic signed [31:0]       rec_salary,
    output logic                     last_of_run
);

    import krt_pkg::*;

    req_t                      req_reg;
    logic signed [FIELD_W-1:0] key_reg;
    logic signed [FIELD_W-1:0] sal_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]         lim_reg, lim_next;
    logic [REC_W-1:0]          carry_reg, carry_next;

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [REC_W-1:0]          wdata;
    logic [ADDR_W-1:0]         raddr;
    logic [REC_W-1:0]          rdata;

    logic signed [FIELD_W-1:0] rd_id;
    logic signed [FIELD_W-1:0] rd_sal;
    logic signed [FIELD_W-1:0] carry_id;
    logic [CNT_W-1:0]          cnt_m1;

    logic                      emit;
    status_t                   emit_status;
    logic signed [FIELD_W-1:0] emit_id;
    logic signed [FIELD_W-1:0] emit_sal;
    logic                      emit_last;

    logic                      done_reg;
    status_t                   status_reg;
    logic signed [FIELD_W-1:0] rec_id_reg;
    logic signed [FIELD_W-1:0] rec_salary_reg;
    logic                      last_reg;

    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_id    = rdata[REC_W-1:FIELD_W];
    assign rd_sal   = rdata[FIELD_W-1:0];
    assign carry_id = carry_reg[REC_W-1:FIELD_W];
    assign cnt_m1   = count_reg - CNT_W'(1);

    assign stat.req      = req_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.few      = (count_reg < CNT_W'(2));
    assign stat.match    = (rd_id == key_reg);
    assign stat.at_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.run_end  = ((idx_reg + ADDR_W'(1)) == lim_reg);
    assign stat.sort_end = (lim_reg == ADDR_W'(1));

    always_comb
    begin
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = carry_reg;
        raddr       = '0;
        count_next  = count_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        carry_next  = carry_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_id     = '0;
        emit_sal    = '0;
        emit_last   = 1'b1;
        case (op)
            OP_INSERT:
            begin
                we         = 1'b1;
                waddr      = count_reg[ADDR_W-1:0];
                wdata      = {key_reg, sal_reg};
                count_next = count_reg + CNT_W'(1);
                emit       = 1'b1;
                emit_id    = key_reg;
                emit_sal   = sal_reg;
            end
            OP_FULL:
            begin
                emit        = 1'b1;
                emit_status = ST_FULL;
            end
            OP_EMPTY:
            begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
            end
            OP_NOTFOUND:
            begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
                emit_id     = key_reg;
            end
            OP_SCAN_INIT, OP_LIST_INIT:
            begin
                idx_next = '0;
            end
            OP_SCAN_NEXT:
            begin
                raddr    = idx_reg + ADDR_W'(1);
                idx_next = idx_reg + ADDR_W'(1);
            end
            OP_SCAN_HIT:
            begin
                emit    = 1'b1;
                emit_id = rd_id;
                if (req_reg == REQ_UPDATE)
                begin
                    we       = 1'b1;
                    wdata    = {rd_id, sal_reg};
                    emit_sal = sal_reg;
                end
                else
                begin
                    emit_sal = rd_sal;
                end
            end
            OP_SORT_INIT:
            begin
                lim_next = cnt_m1[ADDR_W-1:0];
            end
            OP_PASS_LOAD:
            begin
                carry_next = rdata;
                raddr      = ADDR_W'(1);
                idx_next   = '0;
            end
            OP_PASS_RUN:
            begin
                // The larger id rides along in the carry; the smaller one settles here.
                we       = 1'b1;
                raddr    = idx_reg + ADDR_W'(2);
                idx_next = idx_reg + ADDR_W'(1);
                if (carry_id > rd_id)
                begin
                    wdata = rdata;
                end
                else
                begin
                    wdata      = carry_reg;
                    carry_next = rdata;
                end
            end
            OP_PASS_END:
            begin
                we       = 1'b1;
                waddr    = lim_reg;
                wdata    = carry_reg;
                lim_next = lim_reg - ADDR_W'(1);
                idx_next = '0;
            end
            OP_LIST_NEXT:
            begin
                raddr     = idx_reg + ADDR_W'(1);
                idx_next  = idx_reg + ADDR_W'(1);
                emit      = 1'b1;
                emit_id   = rd_id;
                emit_sal  = rd_sal;
                emit_last = stat.at_last;
            end
            default:
            begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_LATCH)
        begin
            req_reg <= req_t'(req_type);
            key_reg <= key_id;
            sal_reg <= salary_value;
        end
        idx_reg   <= idx_next;
        lim_reg   <= lim_next;
        carry_reg <= carry_next;
        if (emit)
        begin
            status_reg     <= emit_status;
            rec_id_reg     <= emit_id;
            rec_salary_reg <= emit_sal;
            last_reg       <= emit_last;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign rec_id      = rec_id_reg;
    assign rec_salary  = rec_salary_reg;
    assign last_of_run = last_reg;

endmodule

// ===== rtl/krt_ctrl.sv =====
// Controller state machine that sequences insert, scan, sort and list operations.
module krt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  krt_pkg::dp_stat_t stat,
    output krt_pkg::dp_op_t   op,
    output logic              busy
);

    import krt_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.req)
                    REQ_INSERT:
                    begin
                        op         = stat.full ? OP_FULL : OP_INSERT;
                        state_next = S_IDLE;
                    end
                    REQ_LIST:
                    begin
                        if (stat.empty)
                        begin
                            op         = OP_EMPTY;
                            state_next = S_IDLE;
                        end
                        else if (stat.few)
                        begin
                            op         = OP_LIST_INIT;
                            state_next = S_LIST_OUT;
                        end
                        else
                        begin
                            op         = OP_SORT_INIT;
                            state_next = S_PASS_LOAD;
                        end
                    end
                    REQ_FIND, REQ_UPDATE:
                    begin
                        if (stat.empty)
                        begin
                            op         = OP_NOTFOUND;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            op         = OP_SCAN_INIT;
                            state_next = S_SCAN_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN_CHK:
            begin
                if (stat.match)
                begin
                    op         = OP_SCAN_HIT;
                    state_next = S_IDLE;
                end
                else if (stat.at_last)
                begin
                    op         = OP_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    op = OP_SCAN_NEXT;
                end
            end
            S_PASS_LOAD:
            begin
                op         = OP_PASS_LOAD;
                state_next = S_PASS_RUN;
            end
            S_PASS_RUN:
            begin
                op = OP_PASS_RUN;
                if (stat.run_end)
                begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END:
            begin
                op         = OP_PASS_END;
                state_next = stat.sort_end ? S_LIST_OUT : S_PASS_LOAD;
            end
            S_LIST_OUT:
            begin
                op = OP_LIST_NEXT;
                if (stat.at_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/keyed_record_table_with_sort_top.sv =====
// Top level of the keyed record table: controller plus datapath.
// One transaction is worked at a time. An insert writes one record; a find or update scans
// the records in order until a match; a list sorts the records by id, then sends one record
// per cycle. busy drops on the cycle after the last result is set up. The pace is set by the
// single read port of the record RAM, which sees one compare-and-swap step per cycle. An
// asynchronous low rst_n empties the table and idles the controller; the RAM contents are
// left as they are.
module keyed_record_table_with_sort_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] key_id,
    input  logic signed [31:0] salary_value,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] rec_id,
    output logic signed [31:0] rec_salary,
    output logic               last_of_run
);

    import krt_pkg::*;

    // The controller issues one datapath operation per cycle and reads back a status bundle.
    dp_op_t   op;
    dp_stat_t stat;

    krt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    // The datapath latches the transaction, owns the record RAM and registers every result,
    // so a result appears on the ports for exactly one cycle with done high.
    krt_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .key_id       (key_id),
        .salary_value (salary_value),
        .op           (op),
        .stat         (stat),
        .done         (done),
        .status       (status),
        .rec_id       (rec_id),
        .rec_salary   (rec_salary),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== rtl/krt_checker.sv =====
// Port-level checker for the keyed record table, bound to the top level.
`include "assert_macros.svh"

module krt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         req_type,
    input logic signed [31:0] key_id,
    input logic signed [31:0] salary_value,
    input logic               done,
    input logic [1:0]         status,
    input logic signed [31:0] rec_id,
    input logic signed [31:0] rec_salary,
    input logic               last_of_run
);

    import krt_pkg::*;

    // An accepted transaction holds the block busy on the following cycle.
    `KRT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // No result can appear on the cycle right after a transaction is taken.
    `KRT_ASSERT_NXT(a_accept_no_done, start && !busy, !done)
    // Every error status is a single result and so closes its transaction.
    `KRT_ASSERT_IMP(a_error_last, done && (status != ST_OK), last_of_run)
    // A full or empty report carries a zero record.
    `KRT_ASSERT_IMP(a_zero_record, done && (status == ST_FULL || status == ST_EMPTY),
                    rec_id == 0 && rec_salary == 0)

endmodule

bind keyed_record_table_with_sort_top krt_checker u_krt_checker (.*);
